// ===== sv/v3alu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// v3alu_pkg
// Mode codes, stage payload types and clipping helpers for the vec3_alu.
// ----------------------------------------------------------------------------
package v3alu_pkg;

  localparam logic [3:0] ModeAdd    = 4'd0;
  localparam logic [3:0] ModeSub    = 4'd1;
  localparam logic [3:0] ModeCross  = 4'd2;
  localparam logic [3:0] ModeDot    = 4'd3;
  localparam logic [3:0] ModeScale  = 4'd4;
  localparam logic [3:0] ModeDiv    = 4'd5;
  localparam logic [3:0] ModeNorm   = 4'd6;
  localparam logic [3:0] ModeEqual  = 4'd7;
  localparam logic [3:0] ModeNeg    = 4'd8;
  localparam logic [3:0] ModeSqNorm = 4'd9;

  localparam int unsigned InWidth   = 232;
  localparam int unsigned OutWidth  = 136;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 48;
  localparam int unsigned NumWidth  = 79;

  // result flag positions in the output tdata
  localparam int unsigned EqBit  = 128;
  localparam int unsigned DzBit  = 129;
  localparam int unsigned SatBit = 130;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } clip_t;

  // fields carried alongside the root and quotient pipelines
  typedef struct packed {
    logic [3:0]       mode;
    logic [31:0]      res_x;
    logic [31:0]      res_y;
    logic [31:0]      res_z;
    logic [31:0]      res_sc;
    logic             res_sat;
    logic             near_zero;
    logic             eq;
    logic [2:0]       a_neg;
    logic [2:0][31:0] a_mag;
    logic             s_neg;
    logic             s_zero;
    logic [31:0]      s_mag;
    logic [4:0]       k;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [33:0] rem;
    logic [31:0] root;
    logic [63:0] m;
  } sq_t;

  typedef struct packed {
    side_t            side;
    logic [31:0]      dsr;
    logic [2:0][31:0] rem;
    logic [2:0][47:0] nq;
  } dv_t;

  function automatic logic [32:0] sx33(input logic [31:0] x);
    return {x[31], x};
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  function automatic clip_t clip50(input logic [49:0] x);
    clip_t c;
    if (x[49:31] == {19{x[49]}}) begin
      c.val = x[31:0];
      c.sat = 1'b0;
    end else begin
      c.val = x[49] ? 32'h8000_0000 : 32'h7fff_ffff;
      c.sat = 1'b1;
    end
    return c;
  endfunction

  // signed clip of a magnitude with a separate sign
  function automatic clip_t clip_quot(input logic [47:0] q, input logic neg);
    clip_t c;
    if (!neg) begin
      if (q > 48'h0000_7fff_ffff) begin
        c.val = 32'h7fff_ffff;
        c.sat = 1'b1;
      end else begin
        c.val = q[31:0];
        c.sat = 1'b0;
      end
    end else begin
      if (q > 48'h0000_8000_0000) begin
        c.val = 32'h8000_0000;
        c.sat = 1'b1;
      end else begin
        c.val = ~q[31:0] + 32'd1;
        c.sat = 1'b0;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== sv/vec3_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vec3_alu
// Pipelined Q16.16 three-vector ALU: add, sub, cross, dot, scale, divide,
// normalize, approximate equality, negate and squared norm.
// ----------------------------------------------------------------------------
// One transaction is accepted per cycle while the output is not stalled, and every
// item passes through the 32-step square root and the 48-step restoring
// divider (three lanes), whatever the mode; a stalled output freezes the
// whole pipeline. The threshold register may only be written while no
// transaction is in flight.
module vec3_alu (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [31:0]                        cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // mode[3:0], a_x, a_y, a_z, b_x, b_y, b_z, scalar_in, zero pad
  input  logic [v3alu_pkg::InWidth-1:0]      s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // out_x, out_y, out_z, out_scalar, equal_flag, divide_by_zero, saturated, pad
  output logic [v3alu_pkg::OutWidth-1:0]     m_axis_tdata
);
  import v3alu_pkg::*;

  typedef struct packed {
    logic [3:0]       mode;
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
    logic [31:0]      s;
    logic [5:0][32:0] op_a;
    logic [5:0][32:0] op_b;
    logic             a_nz;
    logic             b_nz;
  } fr_t;

  typedef struct packed {
    logic [3:0]       mode;
    logic [2:0][31:0] a;
    logic [31:0]      s;
    logic [2:0][32:0] sv;
    logic [5:0][65:0] prod;
    logic             a_nz;
    logic             b_nz;
  } mu_t;

  typedef struct packed {
    logic [3:0]       mode;
    logic [2:0][31:0] a;
    logic [31:0]      s;
    logic [2:0][49:0] vec;
    logic [49:0]      sc;
    logic [63:0]      sq;
    logic [65:0]      dsq;
    logic             a_nz;
    logic             b_nz;
  } cb_t;

  typedef struct packed {
    side_t       side;
    logic [63:0] pp_lo;
    logic [63:0] pp_hi;
    logic [65:0] dsq;
    logic [63:0] m;
    logic        a_nz;
    logic        b_nz;
  } n1_t;

  typedef struct packed {
    side_t       side;
    logic [95:0] tsum;
    logic [65:0] dsq;
    logic [63:0] m;
    logic        a_nz;
    logic        b_nz;
  } n2_t;

  logic        en;
  logic [31:0] thr_q;

  fr_t fr_d, fr_q;
  mu_t mu_d, mu_q;
  cb_t cb_d, cb_q;
  n1_t n1_d, n1_q;
  n2_t n2_d, n2_q;
  sq_t sq_d0;
  sq_t sq_q [SqrtSteps+1];
  dv_t dv_d0;
  dv_t dv_q [DivSteps+1];
  logic [OutWidth-1:0] out_d, out_q;

  logic                fr_vld_q, mu_vld_q, cb_vld_q, n1_vld_q, n2_vld_q, out_vld_q;
  logic [SqrtSteps:0]  sq_vld_q;
  logic [DivSteps:0]   dv_vld_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 32'd1;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // ---- input stage: operand selection for the six multipliers
  always_comb begin
    logic [2:0][31:0] in_a, in_b, prim;
    logic [2:0][32:0] dif;
    in_a = s_axis_tdata[99:4];
    in_b = s_axis_tdata[195:100];
    fr_d.mode = s_axis_tdata[3:0];
    fr_d.a    = in_a;
    fr_d.b    = in_b;
    fr_d.s    = s_axis_tdata[227:196];
    fr_d.a_nz = |in_a;
    fr_d.b_nz = |in_b;
    fr_d.op_a = '0;
    fr_d.op_b = '0;
    for (int i = 0; i < 3; i++) begin
      dif[i]  = sx33(in_a[i]) - sx33(in_b[i]);
      prim[i] = fr_d.a_nz ? in_a[i] : in_b[i];
    end
    unique case (fr_d.mode)
      ModeCross: begin
        fr_d.op_a[0] = sx33(in_a[1]); fr_d.op_b[0] = sx33(in_b[2]);
        fr_d.op_a[1] = sx33(in_a[2]); fr_d.op_b[1] = sx33(in_b[1]);
        fr_d.op_a[2] = sx33(in_a[2]); fr_d.op_b[2] = sx33(in_b[0]);
        fr_d.op_a[3] = sx33(in_a[0]); fr_d.op_b[3] = sx33(in_b[2]);
        fr_d.op_a[4] = sx33(in_a[0]); fr_d.op_b[4] = sx33(in_b[1]);
        fr_d.op_a[5] = sx33(in_a[1]); fr_d.op_b[5] = sx33(in_b[0]);
      end
      ModeDot: begin
        for (int i = 0; i < 3; i++) begin
          fr_d.op_a[i] = sx33(in_a[i]);
          fr_d.op_b[i] = sx33(in_b[i]);
        end
      end
      ModeScale: begin
        for (int i = 0; i < 3; i++) begin
          fr_d.op_a[i] = sx33(in_a[i]);
          fr_d.op_b[i] = sx33(fr_d.s);
        end
      end
      ModeNorm, ModeSqNorm: begin
        for (int i = 0; i < 3; i++) begin
          fr_d.op_a[i] = sx33(in_a[i]);
          fr_d.op_b[i] = sx33(in_a[i]);
        end
      end
      ModeEqual: begin
        // squares of the nonzero vector, and of A-B
        for (int i = 0; i < 3; i++) begin
          fr_d.op_a[i]   = sx33(prim[i]);
          fr_d.op_b[i]   = sx33(prim[i]);
          fr_d.op_a[i+3] = dif[i];
          fr_d.op_b[i+3] = dif[i];
        end
      end
      default: begin
      end
    endcase
  end

  // ---- multiply stage
  always_comb begin
    mu_d.mode = fr_q.mode;
    mu_d.a    = fr_q.a;
    mu_d.s    = fr_q.s;
    mu_d.a_nz = fr_q.a_nz;
    mu_d.b_nz = fr_q.b_nz;
    for (int i = 0; i < 6; i++) begin
      mu_d.prod[i] = $signed(fr_q.op_a[i]) * $signed(fr_q.op_b[i]);
    end
    for (int i = 0; i < 3; i++) begin
      unique case (fr_q.mode)
        ModeAdd: mu_d.sv[i] = sx33(fr_q.a[i]) + sx33(fr_q.b[i]);
        ModeSub: mu_d.sv[i] = sx33(fr_q.a[i]) - sx33(fr_q.b[i]);
        ModeNeg: mu_d.sv[i] = 33'd0 - sx33(fr_q.a[i]);
        default: mu_d.sv[i] = '0;
      endcase
    end
  end

  // ---- combine stage: sums of products, floor to Q16.16
  always_comb begin
    logic [65:0]      sum_a;
    logic [2:0][65:0] cd;
    sum_a = mu_q.prod[0] + mu_q.prod[1] + mu_q.prod[2];
    for (int i = 0; i < 3; i++) begin
      cd[i] = mu_q.prod[2*i] - mu_q.prod[2*i+1];
    end
    cb_d.mode = mu_q.mode;
    cb_d.a    = mu_q.a;
    cb_d.s    = mu_q.s;
    cb_d.a_nz = mu_q.a_nz;
    cb_d.b_nz = mu_q.b_nz;
    cb_d.sq   = sum_a[63:0];
    cb_d.dsq  = mu_q.prod[3] + mu_q.prod[4] + mu_q.prod[5];
    cb_d.vec  = '0;
    cb_d.sc   = '0;
    unique case (mu_q.mode)
      ModeAdd, ModeSub, ModeNeg: begin
        for (int i = 0; i < 3; i++) begin
          cb_d.vec[i] = {{17{mu_q.sv[i][32]}}, mu_q.sv[i]};
        end
      end
      ModeCross: begin
        for (int i = 0; i < 3; i++) cb_d.vec[i] = cd[i][65:16];
      end
      ModeScale: begin
        for (int i = 0; i < 3; i++) cb_d.vec[i] = mu_q.prod[i][65:16];
      end
      ModeDot, ModeSqNorm: cb_d.sc = sum_a[65:16];
      default: begin
      end
    endcase
  end

  // ---- clip, zero test, threshold products, first normalising shifts
  always_comb begin
    clip_t       cx, cy, cz, cs;
    logic [63:0] m1;
    logic [4:0]  k1;
    cx = clip50(cb_q.vec[0]);
    cy = clip50(cb_q.vec[1]);
    cz = clip50(cb_q.vec[2]);
    cs = clip50(cb_q.sc);
    m1 = cb_q.sq;
    k1 = 5'd0;
    if (m1[63:32] == 32'd0) begin
      m1 = {m1[31:0], 32'd0};
      k1 = 5'd16;
    end
    if (m1[63:48] == 16'd0) begin
      m1 = {m1[47:0], 16'd0};
      k1 = k1 + 5'd8;
    end
    n1_d.side.mode      = cb_q.mode;
    n1_d.side.res_x     = cx.val;
    n1_d.side.res_y     = cy.val;
    n1_d.side.res_z     = cz.val;
    n1_d.side.res_sc    = cs.val;
    n1_d.side.res_sat   = cx.sat | cy.sat | cz.sat | cs.sat;
    n1_d.side.near_zero = cb_q.sq <= {16'd0, thr_q, 16'd0};
    n1_d.side.eq        = 1'b0;
    for (int i = 0; i < 3; i++) begin
      n1_d.side.a_neg[i] = cb_q.a[i][31];
      n1_d.side.a_mag[i] = mag32(cb_q.a[i]);
    end
    n1_d.side.s_neg  = cb_q.s[31];
    n1_d.side.s_zero = cb_q.s == 32'd0;
    n1_d.side.s_mag  = mag32(cb_q.s);
    n1_d.side.k      = k1;
    n1_d.pp_lo = thr_q * cb_q.sq[31:0];
    n1_d.pp_hi = thr_q * cb_q.sq[63:32];
    n1_d.dsq   = cb_q.dsq;
    n1_d.m     = m1;
    n1_d.a_nz  = cb_q.a_nz;
    n1_d.b_nz  = cb_q.b_nz;
  end

  always_comb begin
    logic [63:0] m2;
    logic [4:0]  k2;
    m2 = n1_q.m;
    k2 = n1_q.side.k;
    if (m2[63:56] == 8'd0) begin
      m2 = {m2[55:0], 8'd0};
      k2 = k2 + 5'd4;
    end
    if (m2[63:60] == 4'd0) begin
      m2 = {m2[59:0], 4'd0};
      k2 = k2 + 5'd2;
    end
    n2_d.side   = n1_q.side;
    n2_d.side.k = k2;
    n2_d.tsum   = {32'd0, n1_q.pp_lo} + {n1_q.pp_hi, 32'd0};
    n2_d.dsq    = n1_q.dsq;
    n2_d.m      = m2;
    n2_d.a_nz   = n1_q.a_nz;
    n2_d.b_nz   = n1_q.b_nz;
  end

  // ---- equality verdict, last shift, root entry
  always_comb begin
    logic ratio_ok;
    ratio_ok = {14'd0, n2_q.dsq, 16'd0} <= n2_q.tsum;
    sq_d0.side = n2_q.side;
    sq_d0.side.eq = (n2_q.side.mode == ModeEqual) &&
                    ((n2_q.a_nz && n2_q.b_nz) ? ratio_ok : n2_q.side.near_zero);
    sq_d0.rem  = '0;
    sq_d0.root = '0;
    if (n2_q.m[63:62] == 2'd0) begin
      sq_d0.m      = {n2_q.m[61:0], 2'd0};
      sq_d0.side.k = n2_q.side.k + 5'd1;
    end else begin
      sq_d0.m = n2_q.m;
    end
  end

  // ---- integer square root, one result bit per stage
  for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
    logic [35:0] rr, tt;
    logic        ge;
    sq_t         nxt;
    always_comb begin
      rr  = {sq_q[g].rem, sq_q[g].m[63:62]};
      tt  = {2'b00, sq_q[g].root, 2'b01};
      ge  = rr >= tt;
      nxt = sq_q[g];
      nxt.rem  = ge ? 34'(rr - tt) : rr[33:0];
      nxt.root = {sq_q[g].root[SqrtSteps-2:0], ge};
      nxt.m    = {sq_q[g].m[61:0], 2'b00};
    end
    always_ff @(posedge clk_i) begin
      if (en) sq_q[g+1] <= nxt;
    end
  end

  // ---- divider set-up: numerator |a| << 16 (<< (16 + k) for normalize), divisor root or |s|
  always_comb begin
    side_t                      sd;
    logic [4:0]                 kk;
    logic [2:0][NumWidth-1:0]   num;
    sd = sq_q[SqrtSteps].side;
    kk = (sd.mode == ModeNorm) ? sd.k : 5'd0;
    dv_d0.side = sd;
    dv_d0.dsr  = (sd.mode == ModeNorm) ? sq_q[SqrtSteps].root : sd.s_mag;
    for (int l = 0; l < 3; l++) begin
      num[l] = NumWidth'(sd.a_mag[l]) << (6'd16 + {1'b0, kk});
      dv_d0.rem[l] = {1'b0, num[l][NumWidth-1:DivSteps]};
      dv_d0.nq[l]  = num[l][DivSteps-1:0];
    end
  end

  // ---- restoring division, three lanes, one quotient bit per stage
  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    logic [2:0][32:0] tt;
    logic [2:0]       ge;
    dv_t              nxt;
    always_comb begin
      nxt = dv_q[g];
      for (int l = 0; l < 3; l++) begin
        tt[l] = {dv_q[g].rem[l], dv_q[g].nq[l][DivSteps-1]};
        ge[l] = tt[l] >= {1'b0, dv_q[g].dsr};
        nxt.rem[l] = ge[l] ? 32'(tt[l] - {1'b0, dv_q[g].dsr}) : tt[l][31:0];
        nxt.nq[l]  = {dv_q[g].nq[l][DivSteps-2:0], ge[l]};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) dv_q[g+1] <= nxt;
    end
  end

  // ---- result selection
  always_comb begin
    side_t            sd;
    clip_t [2:0]      cq;
    logic  [2:0][31:0] v;
    logic  [31:0]     sc;
    logic             eq, dz, sat;
    sd = dv_q[DivSteps].side;
    for (int l = 0; l < 3; l++) begin
      cq[l] = clip_quot(dv_q[DivSteps].nq[l],
                        (sd.mode == ModeDiv) ? (sd.a_neg[l] ^ sd.s_neg) : sd.a_neg[l]);
    end
    v   = '0;
    sc  = '0;
    eq  = 1'b0;
    dz  = 1'b0;
    sat = 1'b0;
    unique case (sd.mode)
      ModeDiv: begin
        if (sd.s_zero) begin
          dz = 1'b1;
        end else begin
          for (int l = 0; l < 3; l++) v[l] = cq[l].val;
          sat = cq[0].sat | cq[1].sat | cq[2].sat;
        end
      end
      ModeNorm: begin
        if (!sd.near_zero) begin
          for (int l = 0; l < 3; l++) v[l] = cq[l].val;
          sat = cq[0].sat | cq[1].sat | cq[2].sat;
        end
      end
      default: begin
        v[0] = sd.res_x;
        v[1] = sd.res_y;
        v[2] = sd.res_z;
        sc   = sd.res_sc;
        eq   = sd.eq;
        sat  = sd.res_sat;
      end
    endcase
    out_d = {5'd0, sat, dz, eq, sc, v[2], v[1], v[0]};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fr_q     <= fr_d;
      mu_q     <= mu_d;
      cb_q     <= cb_d;
      n1_q     <= n1_d;
      n2_q     <= n2_d;
      sq_q[0]  <= sq_d0;
      dv_q[0]  <= dv_d0;
      out_q    <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_vld_q  <= 1'b0;
      mu_vld_q  <= 1'b0;
      cb_vld_q  <= 1'b0;
      n1_vld_q  <= 1'b0;
      n2_vld_q  <= 1'b0;
      sq_vld_q  <= '0;
      dv_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      fr_vld_q  <= s_axis_tvalid;
      mu_vld_q  <= fr_vld_q;
      cb_vld_q  <= mu_vld_q;
      n1_vld_q  <= cb_vld_q;
      n2_vld_q  <= n1_vld_q;
      sq_vld_q  <= {sq_vld_q[SqrtSteps-1:0], n2_vld_q};
      dv_vld_q  <= {dv_vld_q[DivSteps-1:0], sq_vld_q[SqrtSteps]};
      out_vld_q <= dv_vld_q[DivSteps];
    end
  end

`ifndef ASSERT_OFF
  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable({fr_vld_q, mu_vld_q, cb_vld_q, n1_vld_q, n2_vld_q,
                     sq_vld_q, dv_vld_q, out_vld_q}))
    else $error("pipeline valid bits moved during a stall");

  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[DzBit] |->
      m_axis_tdata[127:0] == 128'd0 && !m_axis_tdata[SatBit] && !m_axis_tdata[EqBit])
    else $error("divide by zero result not cleared");

  a_eq_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[EqBit] |->
      m_axis_tdata[127:0] == 128'd0 && !m_axis_tdata[SatBit])
    else $error("equality verdict with nonzero data");
`endif

endmodule
`default_nettype wire
